### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared macros for the concurrent checks of the irrigation controller.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising clock edge outside reset.
`define CHK_PROP(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define CHK_NEXT(lbl, cond, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

`endif

### design/ipr_pkg.sv
// ----------------------------------------------------------------------------
// ipr_pkg
// Types and constants of the irrigation pump and roof controller.
// ----------------------------------------------------------------------------
package ipr_pkg;

   localparam logic [6:0]  PCT_MAX   = 7'd100;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;
   localparam int          CSR_DATA_W = 16;

   typedef enum logic [1:0] {
      ROOF_STOP  = 2'd0,
      ROOF_OPEN  = 2'd1,
      ROOF_CLOSE = 2'd2
   } roof_type;

   typedef enum logic [1:0] {
      DIAG_OK    = 2'd0,
      DIAG_DRY   = 2'd1,
      DIAG_OVER  = 2'd2,
      DIAG_EMPTY = 2'd3
   } diag_type;

   typedef enum logic {
      ACT_TICK    = 1'b0,
      ACT_COMMAND = 1'b1
   } action_type;

   typedef enum logic [2:0] {
      CSR_SOIL_ON    = 3'd0,
      CSR_SOIL_OFF   = 3'd1,
      CSR_TANK_EMPTY = 3'd2,
      CSR_OVERLOAD   = 3'd3,
      CSR_DRY_CUR    = 3'd4,
      CSR_MIN_FLOW   = 3'd5,
      CSR_GRACE      = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic        action;
      logic [6:0]  soil_level;
      logic [6:0]  tank_level;
      logic [14:0] pump_current_ma;
      logic [11:0] flow_tenths;
      logic        raining;
      logic [1:0]  limit_free;
      logic        cmd_mode;
      logic        cmd_pump;
      logic [1:0]  cmd_roof;
      logic [6:0]  cmd_pump_speed;
      logic [6:0]  cmd_roof_speed;
   } req_type;

   typedef struct packed {
      logic       auto_mode;
      logic       pump_on;
      logic [6:0] pump_duty;
      logic [1:0] roof_drive;
      logic [6:0] roof_duty;
      logic [1:0] diagnostic;
      logic       display_refresh;
   } rsp_type;

   typedef struct packed {
      logic [6:0]  soil_on_level;
      logic [6:0]  soil_off_level;
      logic [6:0]  tank_empty_level;
      logic [14:0] overload_ma;
      logic [14:0] dry_current_ma;
      logic [11:0] min_flow_tenths;
      logic [15:0] grace_ticks;
   } cfg_type;

   typedef struct packed {
      logic       mode;
      logic       pump;
      logic [1:0] roof;
      logic [6:0] pump_speed;
      logic [6:0] roof_speed;
   } pend_type;

   typedef struct packed {
      logic        mode;
      logic        pump;
      roof_type    roof;
      logic [6:0]  pump_speed;
      logic [6:0]  roof_speed;
      diag_type    diag;
      logic        pump_was_on;
      logic [15:0] on_count;
      logic        pend_valid;
      pend_type    pend;
   } state_type;

   localparam cfg_type CFG_RESET = '{
      soil_on_level:    7'd30,
      soil_off_level:   7'd80,
      tank_empty_level: 7'd10,
      overload_ma:      15'd2000,
      dry_current_ma:   15'd100,
      min_flow_tenths:  12'd2,
      grace_ticks:      16'd100
   };

   localparam state_type STATE_RESET = '{
      mode:        1'b0,
      pump:        1'b0,
      roof:        ROOF_STOP,
      pump_speed:  7'd100,
      roof_speed:  7'd100,
      diag:        DIAG_OK,
      pump_was_on: 1'b0,
      on_count:    16'd0,
      pend_valid:  1'b0,
      pend:        '0
   };

endpackage

### design/ipr_step.sv
// ----------------------------------------------------------------------------
// ipr_step
// Combinational update of the controller state for one item.
// ----------------------------------------------------------------------------
module ipr_step (
   input  ipr_pkg::state_type st_cur,
   input  ipr_pkg::cfg_type   cfg,
   input  ipr_pkg::req_type   item,
   output ipr_pkg::state_type st_next,
   output ipr_pkg::rsp_type   rsp
);

   always_comb begin
      ipr_pkg::state_type st;
      logic               refresh;
      logic               empty;
      logic               pump_before;

      st          = st_cur;
      refresh     = 1'b0;
      empty       = item.tank_level < cfg.tank_empty_level;
      pump_before = 1'b0;

      if (item.action == ipr_pkg::ACT_COMMAND) begin
         st.pend.mode       = item.cmd_mode;
         st.pend.pump       = item.cmd_pump;
         st.pend.roof       = item.cmd_roof;
         st.pend.pump_speed = item.cmd_pump_speed;
         st.pend.roof_speed = item.cmd_roof_speed;
         st.pend_valid      = 1'b1;
      end else begin
         // A pending remote command takes effect first.
         if (st.pend_valid) begin
            st.mode = st.pend.mode;
            st.pump = st.pend.pump & ~empty;
            if (st.pend.roof > ipr_pkg::ROOF_CLOSE) begin
               st.roof = ipr_pkg::ROOF_STOP;
            end else begin
               st.roof = ipr_pkg::roof_type'(st.pend.roof);
            end
            st.pump_speed = (st.pend.pump_speed > ipr_pkg::PCT_MAX) ?
                            ipr_pkg::PCT_MAX : st.pend.pump_speed;
            st.roof_speed = (st.pend.roof_speed > ipr_pkg::PCT_MAX) ?
                            ipr_pkg::PCT_MAX : st.pend.roof_speed;
            st.pend_valid = 1'b0;
            refresh       = 1'b1;
         end

         // Automatic control: soil hysteresis for the pump, rain for the roof.
         if (st.mode) begin
            pump_before = st.pump;
            if (item.soil_level < cfg.soil_on_level) begin
               st.pump = (st.diag == ipr_pkg::DIAG_OK);
            end else if (item.soil_level > cfg.soil_off_level) begin
               st.pump = 1'b0;
               if (st.diag == ipr_pkg::DIAG_DRY || st.diag == ipr_pkg::DIAG_OVER) begin
                  st.diag = ipr_pkg::DIAG_OK;
               end
            end
            if (empty) begin
               st.pump = 1'b0;
            end
            if (pump_before != st.pump) begin
               refresh = 1'b1;
            end

            if (item.raining) begin
               if (st.roof != ipr_pkg::ROOF_CLOSE && item.limit_free[0]) begin
                  st.roof = ipr_pkg::ROOF_CLOSE;
                  refresh = 1'b1;
               end
            end else if (st.roof == ipr_pkg::ROOF_CLOSE) begin
               st.roof = ipr_pkg::ROOF_STOP;
               refresh = 1'b1;
            end else if (st.roof != ipr_pkg::ROOF_OPEN && item.limit_free[1]) begin
               st.roof = ipr_pkg::ROOF_OPEN;
               refresh = 1'b1;
            end
         end

         // Protection, with a grace count after the pump starts.
         if (empty) begin
            if (st.pump) begin
               st.pump = 1'b0;
               refresh = 1'b1;
            end
            st.diag = ipr_pkg::DIAG_EMPTY;
         end else if (st.pump) begin
            if (!st.pump_was_on) begin
               st.on_count = '0;
            end else if (st.on_count != ipr_pkg::COUNT_MAX) begin
               st.on_count = st.on_count + 16'd1;
            end
            if (st.on_count < cfg.grace_ticks) begin
               st.diag = st.diag;
            end else if (item.pump_current_ma > cfg.overload_ma) begin
               st.diag = ipr_pkg::DIAG_OVER;
               st.pump = 1'b0;
               refresh = 1'b1;
            end else if (item.pump_current_ma < cfg.dry_current_ma ||
                         item.flow_tenths < cfg.min_flow_tenths) begin
               st.diag = ipr_pkg::DIAG_DRY;
               st.pump = 1'b0;
               refresh = 1'b1;
            end else begin
               st.diag = ipr_pkg::DIAG_OK;
            end
         end else if (st.diag == ipr_pkg::DIAG_EMPTY) begin
            st.diag = ipr_pkg::DIAG_OK;
         end
         st.pump_was_on = st.pump;
      end

      st_next             = st;
      rsp.auto_mode       = st.mode;
      rsp.pump_on         = st.pump;
      rsp.pump_duty       = st.pump ? st.pump_speed : 7'd0;
      rsp.roof_drive      = st.roof;
      rsp.roof_duty       = (st.roof != ipr_pkg::ROOF_STOP) ? st.roof_speed : 7'd0;
      rsp.diagnostic      = st.diag;
      rsp.display_refresh = refresh;
   end

endmodule

### design/irrigation_pump_roof_controller_unit.sv
// ----------------------------------------------------------------------------
// irrigation_pump_roof_controller_unit
// Pump and greenhouse roof controller driven by sensor ticks and commands.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while req_stall is low and
// returns exactly one result item for each, in order. An item passes
// through an input register and then a result register, which offers its
// result until the receiver takes it; the controller state is updated in
// the cycle the item moves from the input register to the result register,
// so the item right behind it already sees the new state. A command item
// only stores a remote command, which is applied at the start of the next
// tick item; its result reports the present state with display_refresh
// low. A tick item applies that command, runs automatic control in auto
// mode and then protection (tank empty, overload, dry run). The result
// register lets a new item enter while a finished result waits for the
// receiver. Thresholds are written through the csr_ port, which is always
// ready; writes are meant only while no item is in flight. Indexes beyond
// the last register are ignored.
module irrigation_pump_roof_controller_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  ipr_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output ipr_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [2:0]                            csr_index,
   input  logic [ipr_pkg::CSR_DATA_W-1:0]        csr_data
);

   // Input register.
   logic               in_valid_ff, in_valid_in;
   ipr_pkg::req_type   in_data_ff;

   // Result register.
   logic               out_valid_ff, out_valid_in;
   ipr_pkg::rsp_type   out_data_ff;

   // Controller state and thresholds.
   ipr_pkg::state_type state_ff, state_in;
   ipr_pkg::cfg_type   cfg_ff, cfg_in;

   ipr_pkg::rsp_type   step_rsp;
   logic               advance;
   logic               accept;

   // The item in the input register moves on when the result register is
   // free or is being emptied in this cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign csr_ready = 1'b1;

   ipr_step u_step (
      .st_cur  (state_ff),
      .cfg     (cfg_ff),
      .item    (in_data_ff),
      .st_next (state_in),
      .rsp     (step_rsp)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            ipr_pkg::CSR_SOIL_ON:    cfg_in.soil_on_level    = csr_data[6:0];
            ipr_pkg::CSR_SOIL_OFF:   cfg_in.soil_off_level   = csr_data[6:0];
            ipr_pkg::CSR_TANK_EMPTY: cfg_in.tank_empty_level = csr_data[6:0];
            ipr_pkg::CSR_OVERLOAD:   cfg_in.overload_ma      = csr_data[14:0];
            ipr_pkg::CSR_DRY_CUR:    cfg_in.dry_current_ma   = csr_data[14:0];
            ipr_pkg::CSR_MIN_FLOW:   cfg_in.min_flow_tenths  = csr_data[11:0];
            ipr_pkg::CSR_GRACE:      cfg_in.grace_ticks      = csr_data[15:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= ipr_pkg::STATE_RESET;
         cfg_ff       <= ipr_pkg::CFG_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff       <= cfg_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= step_rsp;
      end
   end

endmodule

### design/ipr_checker.sv
// ----------------------------------------------------------------------------
// ipr_checker
// Port-level checks of the irrigation controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ipr_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ipr_pkg::rsp_type rsp_data
);

   // A result held back by the receiver stays as it was.
   `CHK_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data),
             "result changed while stalled")

   // Nothing is offered in the cycle after reset.
   `CHK_PROP(a_reset_idle, $past(reset) |-> !rsp_valid, "result offered right after reset")

   // Duties never pass full scale and the roof drive code stays defined.
   `CHK_PROP(a_duty_range,
             rsp_valid |-> rsp_data.pump_duty <= ipr_pkg::PCT_MAX &&
                rsp_data.roof_duty <= ipr_pkg::PCT_MAX &&
                rsp_data.roof_drive <= ipr_pkg::ROOF_CLOSE,
             "duty or roof drive out of range")

   // Duties read zero when their drive is off.
   `CHK_PROP(a_duty_zero,
             rsp_valid |-> (rsp_data.pump_on || rsp_data.pump_duty == 7'd0) &&
                (rsp_data.roof_drive != ipr_pkg::ROOF_STOP || rsp_data.roof_duty == 7'd0),
             "duty set with drive off")

endmodule

bind irrigation_pump_roof_controller_unit ipr_checker u_ipr_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
